[src/wiegand_to_spi_bridge_core_assert.svh]
// Assertion macros for the Wiegand to SPI bridge core.
`ifndef WIEGAND_TO_SPI_BRIDGE_CORE_ASSERT_SVH
`define WIEGAND_TO_SPI_BRIDGE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define WSB_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("wsb assertion failed");
`define WSB_ASSERT_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("wsb forbidden condition seen");
`else
`define WSB_ASSERT(name, clk, rst_n, prop)
`define WSB_ASSERT_NEVER(name, clk, rst_n, expr)
`endif

`endif

[src/wsb_pkg.sv]
// Shared constants and types of the Wiegand to SPI bridge.
package wsb_pkg;

    localparam int FRAME_BYTES    = 4;
    localparam int SHIFT_W        = 32;
    localparam int MAX_FRAME_BITS = 32;
    localparam int FRAME_BITS_W   = 6;
    localparam int SEND_IDX_W     = $clog2(FRAME_BYTES + 1);

    localparam logic [FRAME_BITS_W-1:0] FRAME_BITS_RESET = 6'd26;
    localparam logic [7:0]              IDLE_BYTE        = 8'hFF;
    localparam logic [7:0]              LED_RESET        = 8'hF8;

    localparam logic REQ_SAMPLE   = 1'b0;
    localparam logic REQ_SPI_DONE = 1'b1;

    typedef struct packed {
        logic req_type;
        logic line_zero_level;
        logic line_one_level;
    } t_req_item;

    typedef struct packed {
        logic       spi_load_valid;
        logic [7:0] spi_load_byte;
        logic [7:0] led_pattern;
        logic       frame_pending;
    } t_res_item;

    typedef struct packed {
        logic                    pending;
        logic [FRAME_BITS_W-1:0] bit_count;
    } t_step_status;

    // Which data line must return high before another pulse is taken.
    typedef enum logic [2:0] {
        WAIT_NONE = 3'b001,
        WAIT_ZERO = 3'b010,
        WAIT_ONE  = 3'b100
    } t_wait_state;

endpackage

[src/wsb_if.sv]
// Channel interfaces of the Wiegand to SPI bridge.
interface wsb_req_if;
    import wsb_pkg::*;
    logic valid;
    logic ready;
    logic req_type;
    logic line_zero_level;
    logic line_one_level;
    modport source (output valid, req_type, line_zero_level, line_one_level, input ready);
    modport sink   (input valid, req_type, line_zero_level, line_one_level, output ready);
endinterface

interface wsb_res_if;
    import wsb_pkg::*;
    logic       valid;
    logic       ready;
    logic       spi_load_valid;
    logic [7:0] spi_load_byte;
    logic [7:0] led_pattern;
    logic       frame_pending;
    modport source (output valid, spi_load_valid, spi_load_byte, led_pattern, frame_pending,
                    input ready);
    modport sink   (input valid, spi_load_valid, spi_load_byte, led_pattern, frame_pending,
                    output ready);
endinterface

interface wsb_cfg_if;
    import wsb_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [FRAME_BITS_W-1:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

[src/wsb_in_reg.sv]
// Input register stage that holds one accepted request.
module wsb_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  wsb_pkg::t_req_item i_item,
    output logic               o_valid,
    input  logic               i_take,
    output wsb_pkg::t_req_item o_item
);
    import wsb_pkg::*;

    logic      r_valid;
    t_req_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

[src/wsb_step.sv]
// Receiver and sender state with the per-request update logic.
module wsb_step (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_fire,
    input  wsb_pkg::t_req_item                   i_item,
    input  logic [wsb_pkg::FRAME_BITS_W-1:0]     i_frame_bits,
    output wsb_pkg::t_res_item                   o_result,
    output wsb_pkg::t_step_status                o_status
);
    import wsb_pkg::*;

    logic [SHIFT_W-1:0]      r_shift_word, n_shift_word;
    logic [FRAME_BITS_W-1:0] r_bit_count, n_bit_count;
    logic                    r_pending, n_pending;
    t_wait_state             r_wait, n_wait;
    logic [SHIFT_W-1:0]      r_send_word, n_send_word;
    logic [SEND_IDX_W-1:0]   r_send_index, n_send_index;
    logic [7:0]              r_led, n_led;

    logic [FRAME_BITS_W-1:0] frame_len;
    logic                    released;
    logic [7:0]              load_byte;

    always_comb begin
        if (i_frame_bits == '0) begin
            frame_len = FRAME_BITS_W'(1);
        end else if (i_frame_bits > FRAME_BITS_W'(MAX_FRAME_BITS)) begin
            frame_len = FRAME_BITS_W'(MAX_FRAME_BITS);
        end else begin
            frame_len = i_frame_bits;
        end
    end

    always_comb begin
        n_shift_word = r_shift_word;
        n_bit_count  = r_bit_count;
        n_pending    = r_pending;
        n_wait       = r_wait;
        n_send_word  = r_send_word;
        n_send_index = r_send_index;
        n_led        = r_led;
        released     = 1'b0;
        load_byte    = '0;

        // Line sampling is frozen while a frame is being shifted out.
        if (i_item.req_type == REQ_SAMPLE && r_send_index == '0) begin
            unique case (r_wait)
                WAIT_NONE: released = 1'b1;
                WAIT_ZERO: released = i_item.line_zero_level;
                WAIT_ONE:  released = i_item.line_one_level;
                default:   released = 1'b1;
            endcase
            if (released) begin
                n_wait = WAIT_NONE;
                if (!i_item.line_zero_level) begin
                    n_shift_word = {r_shift_word[SHIFT_W-2:0], 1'b0};
                    n_bit_count  = r_bit_count + FRAME_BITS_W'(1);
                    n_wait       = WAIT_ZERO;
                end else if (!i_item.line_one_level) begin
                    n_shift_word = {r_shift_word[SHIFT_W-2:0], 1'b1};
                    n_bit_count  = r_bit_count + FRAME_BITS_W'(1);
                    n_wait       = WAIT_ONE;
                end
            end
        end

        if (n_bit_count >= frame_len) begin
            n_pending   = 1'b1;
            n_bit_count = '0;
            n_led       = ~n_shift_word[7:0];
        end

        if (i_item.req_type == REQ_SPI_DONE) begin
            if (r_send_index != '0 && r_send_index < SEND_IDX_W'(FRAME_BYTES)) begin
                load_byte    = r_send_word[7:0];
                n_send_word  = r_send_word >> 8;
                n_send_index = r_send_index + SEND_IDX_W'(1);
            end else if (n_pending) begin
                load_byte    = n_shift_word[7:0];
                n_send_word  = n_shift_word >> 8;
                n_shift_word = '0;
                n_pending    = 1'b0;
                n_send_index = SEND_IDX_W'(1);
            end else begin
                load_byte    = IDLE_BYTE;
                n_send_index = '0;
            end
        end

        o_result.spi_load_valid = i_item.req_type == REQ_SPI_DONE;
        o_result.spi_load_byte  = load_byte;
        o_result.led_pattern    = n_led;
        o_result.frame_pending  = n_pending;
    end

    assign o_status.pending   = r_pending;
    assign o_status.bit_count = r_bit_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_word <= '0;
            r_bit_count  <= '0;
            r_pending    <= 1'b0;
            r_wait       <= WAIT_NONE;
            r_send_word  <= '0;
            r_send_index <= '0;
            r_led        <= LED_RESET;
        end else if (i_fire) begin
            r_shift_word <= n_shift_word;
            r_bit_count  <= n_bit_count;
            r_pending    <= n_pending;
            r_wait       <= n_wait;
            r_send_word  <= n_send_word;
            r_send_index <= n_send_index;
            r_led        <= n_led;
        end
    end

endmodule

[src/wiegand_to_spi_bridge_core.sv]
// Top level of the Wiegand to SPI bridge core.
// Each request is either a sample of the two active-low Wiegand data lines or
// the completion of an SPI byte, and each produces exactly one result carrying
// the byte to load (the next frame byte, low byte first, or 0xFF when idle),
// the LED pattern and the frame-pending flag. The block takes one request per
// clock cycle while the result side does not stall. An accepted request is held
// in the input register and its result is then written to the result register,
// with all state updated by a single level of logic between them. A frame-length
// write takes effect on the next processed request and is always accepted at
// once.
`include "wiegand_to_spi_bridge_core_assert.svh"

module wiegand_to_spi_bridge_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wsb_req_if.sink    i_req,
    wsb_cfg_if.sink    i_cfg,
    wsb_res_if.source  o_res
);
    import wsb_pkg::*;

    t_req_item               req_item;
    t_req_item               stage_item;
    logic                    stage_valid;
    logic                    fire;
    t_res_item               step_result;
    t_step_status            st;
    logic [FRAME_BITS_W-1:0] r_frame_bits;
    logic                    r_out_valid;
    t_res_item               r_out;

    assign req_item.req_type        = i_req.req_type;
    assign req_item.line_zero_level = i_req.line_zero_level;
    assign req_item.line_one_level  = i_req.line_one_level;

    assign fire = stage_valid && (!r_out_valid || o_res.ready);

    wsb_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_item  (req_item),
        .o_valid (stage_valid),
        .i_take  (fire),
        .o_item  (stage_item)
    );

    wsb_step u_step (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (stage_item),
        .i_frame_bits (r_frame_bits),
        .o_result     (step_result),
        .o_status     (st)
    );

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_bits <= FRAME_BITS_RESET;
        end else if (i_cfg.valid) begin
            r_frame_bits <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= step_result;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.spi_load_valid = r_out.spi_load_valid;
    assign o_res.spi_load_byte  = r_out.spi_load_byte;
    assign o_res.led_pattern    = r_out.led_pattern;
    assign o_res.frame_pending  = r_out.frame_pending;

    // A sample result never carries a load byte.
    `WSB_ASSERT(a_no_byte_on_sample, i_clk, i_rst_n, (o_res.valid && !o_res.spi_load_valid) |-> (o_res.spi_load_byte == 8'h00))
    // The bit counter is always cleared once it reaches the longest frame.
    `WSB_ASSERT_NEVER(a_bit_count_bound, i_clk, i_rst_n, st.bit_count >= FRAME_BITS_W'(MAX_FRAME_BITS))
    // The held result reports the pending flag that the state now holds.
    `WSB_ASSERT(a_pending_matches, i_clk, i_rst_n, r_out_valid |-> (o_res.frame_pending == st.pending))
    // An accepted request is waiting in the input stage on the next cycle.
    `WSB_ASSERT(a_req_staged, i_clk, i_rst_n, (i_req.valid && i_req.ready) |=> stage_valid)

endmodule
